### hdl/aadl_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the area-average line downscaler.
// No dependencies; every other file of the block but the checker imports this package.
package aadl_pkg;

  localparam int PIX_W        = 8;
  localparam int OLD_W        = 13;
  localparam int NEW_W        = 12;
  localparam int POS_W        = 24;
  localparam int SUM_W        = 20;
  localparam int QUO_W        = 8;
  localparam int DIV_STEPS    = QUO_W;
  localparam int CNT_W        = $clog2(DIV_STEPS);
  localparam int CHANNELS_DEF = 4;
  localparam int MAX_LINE     = 4096;
  localparam int ADDR_W       = 3;
  localparam int DATA_W       = 32;

  localparam logic [OLD_W-1:0] RESET_OLD = OLD_W'(2);
  localparam logic [NEW_W-1:0] RESET_NEW = NEW_W'(1);
  localparam logic [OLD_W-1:0] MIN_OLD   = OLD_W'(2);
  localparam logic [OLD_W-1:0] MAX_OLD   = OLD_W'(MAX_LINE);
  localparam logic [NEW_W-1:0] MIN_NEW   = NEW_W'(1);

  // register index, taken from paddr[2]
  localparam logic REG_OLD_SIZE = 1'b0;
  localparam logic REG_NEW_SIZE = 1'b1;

  typedef struct packed {
    logic load_pix;
    logic step;
    logic div_step;
    logic load_out;
  } aadl_cmd_t;

  typedef struct packed {
    logic close;
  } aadl_stat_t;

endpackage

### hdl/area_average_downscale_line.sv
`timescale 1ns / 1ps
// Top level of the area-average line downscaler: config registers,
// controller and datapath. Depends on aadl_pkg, aadl_regs, aadl_ctrl, aadl_datapath.
//
//  channel  | handshake             | payload
//  ---------+-----------------------+--------------------------------------
//  input    | in_valid / in_ready   | chan_0 .. chan_3 (one source pixel)
//  output   | out_valid / out_ready | out_0 .. out_3, line_last
//  config   | APB psel/penable      | old_size @ 0x0, new_size @ 0x4
//
// Sequence: an item that stays inside the open region is accepted and
// accumulated. An item that closes a region is accepted, accumulated, run
// through the per-channel restoring divider (8 quotient-bit iterations) and
// loaded into the output register; no new item is accepted until it is done.
// Reset: synchronous, clears the controller, positions and sums, and loads
// old_size = 2, new_size = 1. Any register write restarts the line.
// Stalls: the output register holds a result while out_ready is low; the
// next item is accepted and accumulated meanwhile, and only a second
// closing item waits for the output register to free up.
module area_average_downscale_line #(
  parameter int CHANNELS = aadl_pkg::CHANNELS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  // source pixel in
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [7:0]                  chan_0,
  input  logic [7:0]                  chan_1,
  input  logic [7:0]                  chan_2,
  input  logic [7:0]                  chan_3,
  // averaged pixel out
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [7:0]                  out_0,
  output logic [7:0]                  out_1,
  output logic [7:0]                  out_2,
  output logic [7:0]                  out_3,
  output logic                        line_last,
  // configuration
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [aadl_pkg::ADDR_W-1:0] paddr,
  input  logic [aadl_pkg::DATA_W-1:0] pwdata,
  output logic [aadl_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);
  import aadl_pkg::*;

  aadl_cmd_t                         cmd;
  aadl_stat_t                        stat;
  logic [OLD_W-1:0]                  old_size;
  logic [NEW_W-1:0]                  new_size;
  logic [POS_W-1:0]                  line_span;
  logic                              restart;
  logic [3:0][PIX_W-1:0]             pix_all;
  logic [3:0][QUO_W-1:0]             out_all;
  logic [CHANNELS-1:0][QUO_W-1:0]    res;

  // gather the pixel; lanes above CHANNELS are dropped
  assign pix_all = {chan_3, chan_2, chan_1, chan_0};

  aadl_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .old_size  (old_size),
    .new_size  (new_size),
    .line_span (line_span),
    .restart   (restart)
  );

  aadl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  aadl_datapath #(
    .CHANNELS (CHANNELS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .restart   (restart),
    .old_size  (old_size),
    .new_size  (new_size),
    .line_span (line_span),
    .pix       (pix_all[CHANNELS-1:0]),
    .res       (res),
    .res_last  (line_last)
  );

  // unused channels read as zero
  for (genvar k = 0; k < 4; k++) begin : g_out
    if (k < CHANNELS) begin : g_used
      assign out_all[k] = res[k];
    end else begin : g_zero
      assign out_all[k] = '0;
    end
  end

  assign out_0 = out_all[0];
  assign out_1 = out_all[1];
  assign out_2 = out_all[2];
  assign out_3 = out_all[3];

endmodule

### hdl/aadl_regs.sv
`timescale 1ns / 1ps
// Configuration registers: APB write/read, size clamping, line span product.
// Depends on aadl_pkg.
module aadl_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [aadl_pkg::ADDR_W-1:0] paddr,
  input  logic [aadl_pkg::DATA_W-1:0] pwdata,
  output logic [aadl_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  output logic [aadl_pkg::OLD_W-1:0]  old_size,
  output logic [aadl_pkg::NEW_W-1:0]  new_size,
  output logic [aadl_pkg::POS_W-1:0]  line_span,
  output logic                        restart
);
  import aadl_pkg::*;

  logic               wr;
  logic               idx;
  logic [OLD_W-1:0]   cand_old;
  logic [NEW_W-1:0]   cand_new;
  logic [OLD_W-1:0]   old_size_next;
  logic [NEW_W-1:0]   new_size_next;
  logic [OLD_W+NEW_W-1:0] span_full;

  assign pready  = 1'b1;
  assign wr      = psel & penable & pwrite;
  assign idx     = paddr[2];

  always_comb begin
    cand_old = (wr && idx == REG_OLD_SIZE) ? pwdata[OLD_W-1:0] : old_size;
    cand_new = (wr && idx == REG_NEW_SIZE) ? pwdata[NEW_W-1:0] : new_size;
    if (cand_old < MIN_OLD) begin
      old_size_next = MIN_OLD;
    end else if (cand_old > MAX_OLD) begin
      old_size_next = MAX_OLD;
    end else begin
      old_size_next = cand_old;
    end
    // keep new_size strictly below old_size
    if (cand_new < MIN_NEW) begin
      new_size_next = MIN_NEW;
    end else if ({1'b0, cand_new} >= old_size_next) begin
      new_size_next = NEW_W'(old_size_next - OLD_W'(1));
    end else begin
      new_size_next = cand_new;
    end
  end

  assign span_full = old_size * new_size;

  // restart is raised in the cycle after the write so the line starts from the new sizes
  always_ff @(posedge clk) begin
    if (rst) begin
      old_size  <= RESET_OLD;
      new_size  <= RESET_NEW;
      line_span <= POS_W'(RESET_OLD * RESET_NEW);
      restart   <= 1'b0;
    end else begin
      if (wr) begin
        old_size <= old_size_next;
        new_size <= new_size_next;
      end
      line_span <= span_full[POS_W-1:0];
      restart   <= wr;
    end
  end

  always_comb begin
    unique case (idx)
      REG_OLD_SIZE: prdata = DATA_W'(old_size);
      REG_NEW_SIZE: prdata = DATA_W'(new_size);
      default:      prdata = '0;
    endcase
  end

endmodule

### hdl/aadl_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine: input handshake, divide sequencing, output valid.
// Depends on aadl_pkg.
module aadl_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  logic                   out_ready,
  input  aadl_pkg::aadl_stat_t   stat,
  output aadl_pkg::aadl_cmd_t    cmd
);
  import aadl_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_STEP = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  logic [1:0]       state;
  logic [1:0]       state_next;
  logic [CNT_W-1:0] cnt;
  logic             out_free;

  assign in_ready = (state == S_IDLE) && !rst;
  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next   = state;
    cmd          = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.load_pix = 1'b1;
          state_next   = S_STEP;
        end
      end
      S_STEP: begin
        cmd.step   = 1'b1;
        state_next = stat.close ? S_DIV : S_IDLE;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt == CNT_W'(DIV_STEPS - 1)) begin
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        // hold the quotient until the output register frees up
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= (state == S_DIV) ? cnt + CNT_W'(1) : '0;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

### hdl/aadl_datapath.sv
`timescale 1ns / 1ps
// Datapath: position counters, weighted channel sums, per-channel
// restoring dividers and output register. Depends on aadl_pkg.
module aadl_datapath #(
  parameter int CHANNELS = aadl_pkg::CHANNELS_DEF
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  aadl_pkg::aadl_cmd_t                      cmd,
  output aadl_pkg::aadl_stat_t                     stat,
  input  logic                                     restart,
  input  logic [aadl_pkg::OLD_W-1:0]               old_size,
  input  logic [aadl_pkg::NEW_W-1:0]               new_size,
  input  logic [aadl_pkg::POS_W-1:0]               line_span,
  input  logic [CHANNELS-1:0][aadl_pkg::PIX_W-1:0] pix,
  output logic [CHANNELS-1:0][aadl_pkg::QUO_W-1:0] res,
  output logic                                     res_last
);
  import aadl_pkg::*;

  logic [POS_W-1:0] source_start;
  logic [POS_W-1:0] region_end;
  logic [POS_W-1:0] pix_end;
  logic             close;
  logic             last;
  logic             last_pend;
  logic [NEW_W-1:0] part;
  logic [NEW_W-1:0] rest;
  logic [NEW_W-1:0] weight;
  logic [POS_W-1:0] part_full;
  logic [POS_W-1:0] rest_full;

  assign pix_end   = source_start + POS_W'(new_size);
  assign close     = (pix_end >= region_end);
  assign part_full = region_end - source_start;
  assign rest_full = pix_end - region_end;
  assign part      = part_full[NEW_W-1:0];
  assign rest      = rest_full[NEW_W-1:0];
  assign weight    = close ? part : new_size;
  assign last      = (region_end >= line_span);
  assign stat.close = close;

  always_ff @(posedge clk) begin
    if (rst) begin
      source_start <= '0;
      region_end   <= POS_W'(RESET_OLD);
    end else if (restart) begin
      source_start <= '0;
      region_end   <= POS_W'(old_size);
    end else if (cmd.step) begin
      if (close && last) begin
        source_start <= '0;
        region_end   <= POS_W'(old_size);
      end else begin
        source_start <= pix_end;
        if (close) begin
          region_end <= region_end + POS_W'(old_size);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step && close) begin
      last_pend <= last;
    end
    if (cmd.load_out) begin
      res_last <= last_pend;
    end
  end

  for (genvar c = 0; c < CHANNELS; c++) begin : g_lane
    logic [PIX_W-1:0] pix_r;
    logic [SUM_W-1:0] sum;
    logic [SUM_W-1:0] sum_new;
    logic [SUM_W-1:0] rest_prod;
    logic [OLD_W-1:0] div_rem;
    logic [QUO_W-1:0] div_low;
    logic [OLD_W:0]   trial;
    logic [OLD_W:0]   diff;
    logic             ge;

    assign sum_new   = sum + SUM_W'(weight) * SUM_W'(pix_r);
    assign rest_prod = SUM_W'(rest) * SUM_W'(pix_r);

    // one quotient bit a cycle; the top bits start below old_size
    assign trial = {div_rem, div_low[QUO_W-1]};
    assign ge    = (trial >= {1'b0, old_size});
    assign diff  = trial - {1'b0, old_size};

    always_ff @(posedge clk) begin
      if (cmd.load_pix) begin
        pix_r <= pix[c];
      end
      if (rst || restart) begin
        sum <= '0;
      end else if (cmd.step) begin
        if (!close) begin
          sum <= sum_new;
        end else if (last) begin
          sum <= '0;
        end else begin
          sum <= rest_prod;
        end
      end
      if (cmd.step && close) begin
        div_rem <= OLD_W'(sum_new[SUM_W-1:QUO_W]);
        div_low <= sum_new[QUO_W-1:0];
      end else if (cmd.div_step) begin
        div_rem <= ge ? diff[OLD_W-1:0] : trial[OLD_W-1:0];
        div_low <= {div_low[QUO_W-2:0], ge};
      end
      if (cmd.load_out) begin
        res[c] <= div_low;
      end
    end
  end

endmodule

### hdl/aadl_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the area-average line downscaler, bound to the top.
// Depends on area_average_downscale_line.
module aadl_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_0,
  input logic [7:0] out_1,
  input logic [7:0] out_2,
  input logic [7:0] out_3,
  input logic       line_last
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_0) && $stable(out_1)
      && $stable(out_2) && $stable(out_3) && $stable(line_last))
    else $error("stalled result changed");

  // one item at a time: drop ready right after an accept
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("item accepted while previous one still in work");

  // a result never rises directly after an accept or after the accumulate step that follows it
  a_out_latency: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !$past(in_valid && in_ready) && !$past(in_valid && in_ready, 2))
    else $error("result appeared too soon after accept");

  // reset empties the output register
  a_reset_out: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind area_average_downscale_line aadl_checker u_aadl_checker (.*);

### bench/area_average_downscale_line_test.sv
`timescale 1ns / 1ps
// Self-checking bench for the area-average line downscaler: directed and random pixel
// lines, APB size writes, random gaps on both channels. Depends on aadl_pkg and the RTL.
module area_average_downscale_line_test;
  import aadl_pkg::*;

  typedef logic [3:0][7:0] pixel_t;

  typedef struct packed {
    logic [3:0][7:0] chan;
    logic            last;
  } avg_pixel_t;

  localparam int RANDOM_PIXELS = 1600;
  localparam int QUIET_LIMIT   = 2000;   // cycles with no handshake at all
  localparam int SETTLE_CYCLES = 30;     // covers a closing item plus slack

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [7:0]          chan_0 = '0;
  logic [7:0]          chan_1 = '0;
  logic [7:0]          chan_2 = '0;
  logic [7:0]          chan_3 = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [7:0]          out_0, out_1, out_2, out_3;
  logic                line_last;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [ADDR_W-1:0]   paddr = '0;
  logic [DATA_W-1:0]   pwdata = '0;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  area_average_downscale_line dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .chan_0    (chan_0),
    .chan_1    (chan_1),
    .chan_2    (chan_2),
    .chan_3    (chan_3),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_0     (out_0),
    .out_1     (out_1),
    .out_2     (out_2),
    .out_3     (out_3),
    .line_last (line_last),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  // Pixels waiting to be driven, and averaged pixels waiting to come out.
  pixel_t     pixel_q[$];
  avg_pixel_t avg_q[$];

  int pushed_cnt = 0;     // pixels queued by the stimulus
  int taken_cnt  = 0;     // pixels accepted by the block
  int random_sent = 0;
  int errors     = 0;
  int quiet_cycles = 0;

  // Mirror of the line state, kept in scaled positions (units of 1/new_size).
  int unsigned old_sz  = 2;
  int unsigned new_sz  = 1;
  int unsigned src_pos = 0;
  int unsigned region_end = 2;
  int unsigned chan_sum[4] = '{0, 0, 0, 0};

  pixel_t     next_px;
  avg_pixel_t want, got;
  int in_gap = 0, in_calm = 0;
  int out_stall = 0, out_calm = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  // Most gaps are a few cycles, some medium, a rare one long.
  function automatic int draw_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  // Bias channels toward 0 and 255 so full-scale sums show up often.
  function automatic pixel_t rand_pixel();
    pixel_t px;
    for (int c = 0; c < 4; c++) begin
      case ($urandom_range(0, 7))
        0:       px[c] = 8'h00;
        1:       px[c] = 8'hFF;
        default: px[c] = 8'($urandom_range(0, 255));
      endcase
    end
    return px;
  endfunction

  function automatic void restart_line();
    src_pos    = 0;
    region_end = old_sz;
    for (int c = 0; c < 4; c++) chan_sum[c] = 0;
  endfunction

  // Fold one source pixel into the open region; close it when the pixel
  // reaches its end and queue the averaged pixel.
  function automatic void fold_pixel(input pixel_t px);
    int unsigned pix_end, part, rest;
    avg_pixel_t res;
    pix_end = src_pos + new_sz;
    if (pix_end < region_end) begin
      for (int c = 0; c < 4; c++) chan_sum[c] += new_sz * px[c];
      src_pos = pix_end;
    end else begin
      part = region_end - src_pos;
      rest = pix_end - region_end;
      for (int c = 0; c < 4; c++) begin
        chan_sum[c] += part * px[c];
        res.chan[c] = 8'(chan_sum[c] / old_sz);
      end
      res.last = (region_end >= old_sz * new_sz);
      avg_q.push_back(res);
      if (res.last) begin
        restart_line();
      end else begin
        for (int c = 0; c < 4; c++) chan_sum[c] = rest * px[c];
        src_pos    = pix_end;
        region_end += old_sz;
      end
    end
  endfunction

  // APB write: setup, access, done at the edge where pready is seen high.
  // Mirror the register with the same masking and clamping afterwards.
  task automatic set_size(input logic idx, input logic [31:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_OLD_SIZE) old_sz = value & 32'h1FFF;
    else                     new_sz = value & 32'h0FFF;
    if (old_sz < 2) old_sz = 2;
    if (old_sz > MAX_LINE) old_sz = MAX_LINE;
    if (new_sz < 1) new_sz = 1;
    if (new_sz >= old_sz) new_sz = old_sz - 1;
    restart_line();
  endtask

  task automatic set_both(input logic [31:0] old_val, input logic [31:0] new_val);
    if ($urandom_range(0, 1)) begin
      set_size(REG_OLD_SIZE, old_val);
      set_size(REG_NEW_SIZE, new_val);
    end else begin
      set_size(REG_NEW_SIZE, new_val);
      set_size(REG_OLD_SIZE, old_val);
    end
  endtask

  task automatic queue_pixel(input pixel_t px);
    pixel_q.push_back(px);
    pushed_cnt++;
  endtask

  task automatic queue_random(input int count);
    for (int i = 0; i < count; i++) queue_pixel(rand_pixel());
    random_sent += count;
  endtask

  // Hold until every queued pixel is taken and every averaged pixel is out.
  task automatic drain();
    do @(posedge clk); while (taken_cnt != pushed_cnt || avg_q.size() != 0);
  endtask

  // Drain, then let a pixel that closes no region finish inside the block.
  task automatic settle();
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_random_phase();
    int r, o, n, count;
    r = $urandom_range(0, 99);
    if (r < 65) begin
      // short lines, mostly whole lines so line_last comes often
      o = $urandom_range(2, 24);
      n = $urandom_range(1, o - 1);
      count = o * $urandom_range(1, 4);
      if ($urandom_range(0, 3) == 0) count += $urandom_range(1, o - 1);
      set_both(o, n);
    end else if (r < 80) begin
      o = $urandom_range(25, 300);
      n = $urandom_range(1, o - 1);
      count = o;
      set_both(o, n);
    end else if (r < 88) begin
      // any size; new_size may need clamping
      set_both($urandom_range(2, MAX_LINE), $urandom_range(1, 4095));
      count = 40;
    end else if (r < 94) begin
      set_both(MAX_LINE, $urandom_range(0, 1) ? 4095 : 1);
      count = 40;
    end else begin
      // raw 32-bit words: masking and both clamps
      set_both($urandom, $urandom);
      count = 30;
    end
    if (count >= 8 && $urandom_range(0, 3) == 0) begin
      // pause the sender mid-line until every averaged pixel has come out
      queue_random(count / 2);
      drain();
      queue_random(count - count / 2);
    end else begin
      queue_random(count);
    end
    settle();
  endtask

  // Driver: present the next pixel whenever the slot is free, with gaps.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      in_gap   <= 0;
      in_calm  <= 0;
    end else if (!in_valid || in_ready) begin
      if (in_gap != 0) begin
        in_valid <= 1'b0;
        in_gap   <= in_gap - 1;
      end else if (pixel_q.size() != 0) begin
        next_px  = pixel_q.pop_front();
        in_valid <= 1'b1;
        chan_0   <= next_px[0];
        chan_1   <= next_px[1];
        chan_2   <= next_px[2];
        chan_3   <= next_px[3];
        if (in_calm != 0) in_calm <= in_calm - 1;
        else if ($urandom_range(0, 49) == 0) in_calm <= 40;
        else if ($urandom_range(0, 9) < 4) in_gap <= draw_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver back-pressure: random stalls, with stretches of none.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      out_stall <= 0;
      out_calm  <= 0;
    end else if (out_stall != 0) begin
      out_ready <= 1'b0;
      out_stall <= out_stall - 1;
    end else if (out_calm != 0) begin
      out_ready <= 1'b1;
      out_calm  <= out_calm - 1;
    end else if ($urandom_range(0, 99) == 0) begin
      out_ready <= 1'b1;
      out_calm  <= 200;
    end else if ($urandom_range(0, 9) < 2) begin
      out_ready <= 1'b0;
      out_stall <= draw_gap() - 1;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Input monitor: fold each accepted pixel into the mirror.
  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) begin
      fold_pixel({chan_3, chan_2, chan_1, chan_0});
      taken_cnt <= taken_cnt + 1;
    end
  end

  // Output monitor: compare each accepted pixel with the oldest expectation.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      got.chan = {out_3, out_2, out_1, out_0};
      got.last = line_last;
      if (avg_q.size() == 0) begin
        $display("%0t: averaged pixel with none expected: out %h last %b",
                 $time, got.chan, got.last);
        errors++;
      end else begin
        want = avg_q.pop_front();
        for (int c = 0; c < 4; c++) begin
          if (got.chan[c] !== want.chan[c]) begin
            $display("%0t: out_%0d expected %0d actual %0d",
                     $time, c, want.chan[c], got.chan[c]);
            errors++;
          end
        end
        if (got.last !== want.last) begin
          $display("%0t: line_last expected %b actual %b", $time, want.last, got.last);
          errors++;
        end
      end
    end
  end

  // Watchdog: end the run if nothing moves for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) ||
        (psel && penable && pwrite && pready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
      $display("area_average_downscale_line_test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Reset sizes (2 -> 1): extremes and mixed channel values.
    queue_pixel({8'h00, 8'h00, 8'h00, 8'h00});
    queue_pixel({8'hFF, 8'hFF, 8'hFF, 8'hFF});
    queue_pixel({8'hFF, 8'h00, 8'hFF, 8'h00});
    queue_pixel({8'h80, 8'h7F, 8'h01, 8'hFE});
    settle();

    // Largest sizes via oversized old_size; leave the line unfinished.
    set_size(REG_OLD_SIZE, 32'h0000_1FFF);
    set_size(REG_NEW_SIZE, 32'h0000_0FFF);
    queue_pixel({8'hFF, 8'hFF, 8'hFF, 8'hFF});
    queue_pixel({8'h00, 8'h00, 8'h00, 8'h00});
    queue_pixel({8'hFF, 8'hFF, 8'hFF, 8'hFF});
    queue_pixel({8'hFF, 8'h00, 8'hFF, 8'h00});
    queue_pixel({8'h00, 8'hFF, 8'h00, 8'hFF});
    settle();

    // Zero new_size and too-small old_size, both clamped; restarts the line.
    set_size(REG_NEW_SIZE, 32'h0000_0000);
    set_size(REG_OLD_SIZE, 32'h0000_0001);
    queue_pixel({8'hFF, 8'hFF, 8'hFF, 8'hFF});
    queue_pixel({8'hFF, 8'hFF, 8'hFF, 8'hFF});
    settle();

    // 6 -> 4 with junk in the upper bits: some pixels end exactly on region ends.
    set_size(REG_OLD_SIZE, 32'hFFFF_0006);
    set_size(REG_NEW_SIZE, 32'h0FFF_F004);
    queue_pixel({8'hFF, 8'hFF, 8'hFF, 8'hFF});
    queue_pixel({8'hFF, 8'hFF, 8'hFF, 8'hFF});
    queue_pixel({8'hFF, 8'hFF, 8'hFF, 8'hFF});
    queue_pixel({8'h00, 8'h00, 8'h00, 8'h00});
    queue_pixel({8'h12, 8'h34, 8'h56, 8'h78});
    queue_pixel({8'hFE, 8'h01, 8'hAA, 8'h55});
    settle();

    // old_size just above the maximum, new_size masked to zero: no result,
    // and the next write lands mid-line.
    set_size(REG_OLD_SIZE, 32'h0000_1001);
    set_size(REG_NEW_SIZE, 32'h0000_1000);
    queue_pixel({8'hFF, 8'hFF, 8'hFF, 8'hFF});
    queue_pixel({8'h00, 8'h00, 8'h00, 8'h00});
    queue_pixel({8'hFF, 8'hFF, 8'hFF, 8'hFF});
    settle();

    while (random_sent < RANDOM_PIXELS) run_random_phase();

    settle();
    if (avg_q.size() != 0) begin
      $display("%0t: %0d averaged pixels never came out", $time, avg_q.size());
      errors++;
    end
    if (errors == 0) begin
      $display("area_average_downscale_line_test passed");
    end else begin
      $display("area_average_downscale_line_test failed");
    end
    $finish;
  end

endmodule
